// ----- hdl/vnt_pkg.sv -----
// vnt_pkg: shared widths, register codes and helpers for the vertex/normal transform
// used by vertex_normal_transform, vnt_isqrt and vnt_div; no dependencies
`default_nettype none

package vnt_pkg;

    // matrix entry and register layout
    localparam int ENTRY_W = 16;
    localparam int ROW_W   = 64;
    localparam int COF_W   = 33;

    // normal normalisation datapath
    localparam int MAG_W   = 30;
    localparam int SUMSQ_W = 62;
    localparam int ROOT_W  = 31;
    localparam int QUO_W   = 14;
    localparam int DIVD_W  = 43;
    localparam int FRAC_W  = 12;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW0 = 2'd0,
        CFG_ROW1 = 2'd1,
        CFG_ROW2 = 2'd2
    } cfg_reg_t;

    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;

    localparam logic signed [COF_W-1:0] COF_ONE  = 33'sd16777216;
    localparam logic signed [COF_W-1:0] COF_ZERO = 33'sd0;

    // one signed Q4.12 entry of a packed row
    function automatic logic signed [ENTRY_W-1:0] row_entry(input logic [ROW_W-1:0] row,
                                                            input logic [1:0] col);
        return row[ENTRY_W*col +: ENTRY_W];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vnt_isqrt.sv -----
// vnt_isqrt: pipelined floor square root, one root bit per register stage
// depends on vnt_pkg
`default_nettype none

module vnt_isqrt
    import vnt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [SUMSQ_W-1:0] radicand,
    output logic      [ROOT_W-1:0]  root
);

    localparam int CMP_W = SUMSQ_W + 2;

    logic [SUMSQ_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [SUMSQ_W-1:0] rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [CMP_W-1:0]   trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // try setting this root bit: (root + 2^b)^2 against the remainder
        assign trial = (CMP_W'(root_in) << (B + 1)) + (CMP_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (CMP_W'(rem_in) >= trial)
                begin
                    rem_reg[k]  <= rem_in - trial[SUMSQ_W-1:0];
                    root_reg[k] <= root_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hdl/vnt_div.sv -----
// vnt_div: pipelined restoring divider, one quotient bit per register stage
// depends on vnt_pkg; quotient must fit QUO_W bits
`default_nettype none

module vnt_div
    import vnt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [ROOT_W-1:0] divisor,
    output logic      [QUO_W-1:0]  quotient
);

    localparam int CMP_W = ROOT_W + QUO_W;

    logic [DIVD_W-1:0] rem_reg [QUO_W];
    logic [ROOT_W-1:0] dvs_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int B = QUO_W - 1 - k;
        logic [DIVD_W-1:0] rem_in;
        logic [ROOT_W-1:0] dvs_in;
        logic [QUO_W-1:0]  quo_in;
        logic [CMP_W-1:0]  shifted;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // subtract the shifted divisor when it fits
        assign shifted = CMP_W'(dvs_in) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvs_reg[k] <= dvs_in;
                if (CMP_W'(rem_in) >= shifted)
                begin
                    rem_reg[k] <= rem_in - shifted[DIVD_W-1:0];
                    quo_reg[k] <= quo_in | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= quo_in;
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// ----- hdl/vertex_normal_transform.sv -----
// vertex_normal_transform: top level, affine position transform and normal transform
// depends on vnt_pkg, vnt_isqrt, vnt_div
`default_nettype none

// Takes one vertex transaction per cycle while item_stall is low and returns one
// result per transaction, in order. Positions are multiplied by the 3x4 matrix as
// (x,y,z,1) with rounding and saturation; normals go through the sign-corrected
// cofactor matrix and are normalised to unit length (4096). The normalisation path
// holds the 31-stage square root and the 14-stage divider, which positions also
// travel through. A write to a matrix row starts a cofactor and determinant update,
// during which cfg_ready is low and item_stall is high.
// The whole pipeline advances unless a finished result is held by result_stall.
module vertex_normal_transform
    import vnt_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          kind,
    input  wire logic signed [COORD_WIDTH-1:0] coord_x,
    input  wire logic signed [COORD_WIDTH-1:0] coord_y,
    input  wire logic signed [COORD_WIDTH-1:0] coord_z,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               result_kind,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [ROW_W-1:0]              cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int PP_W   = ENTRY_W + CW;
    localparam int PA_W   = PP_W + 3;
    localparam int NP_W   = COF_W + CW;
    localparam int TW     = NP_W + 2;
    localparam int PW     = $clog2(TW);
    localparam int PRE    = (CW > 30) ? 2 : 0;
    localparam int LATE   = ROOT_W + QUO_W + 1;
    localparam int DP_W   = ENTRY_W + COF_W;
    localparam int DET_W  = DP_W + 2;
    localparam int NORM_MSB = MAG_W - 1;

    localparam logic signed [PA_W-1:0] POS_MAX = PA_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [PA_W-1:0] POS_MIN = PA_W'(-(64'sd1 <<< (CW - 1)));
    localparam logic signed [PA_W-1:0] ROUND_HALF = PA_W'(2048);

    typedef struct packed {
        logic                     kind;
        logic                     byp;
        logic [2:0]               neg;
        logic [2:0][CW-1:0]       val;
    } side_t;

    typedef logic [2:0][MAG_W-1:0] nm_t;

    // ------------------------------------------------------------------
    // configuration registers and cofactor update
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]        row_reg [3];
    logic signed [COF_W-1:0] cof_reg [3][3];
    logic                    frozen_reg;
    logic [3:0]              rc_vld_reg;
    logic                    rc_busy;
    logic                    cfg_fire;

    logic signed [ENTRY_W-1:0]   a [3][3];
    logic signed [2*ENTRY_W-1:0] pa [9];
    logic signed [2*ENTRY_W-1:0] pb [9];
    logic signed [2*ENTRY_W-1:0] rc_pa_reg [9];
    logic signed [2*ENTRY_W-1:0] rc_pb_reg [9];
    logic signed [COF_W-1:0]     rc_cof_reg [9];
    logic signed [DP_W-1:0]      rc_dp_reg [3];
    logic signed [DET_W-1:0]     det;

    assign rc_busy   = |rc_vld_reg;
    assign cfg_ready = !rc_busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // row write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_ROW0: row_reg[0] <= cfg_data;
                CFG_ROW1: row_reg[1] <= cfg_data;
                CFG_ROW2: row_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // unpack the linear part
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = row_entry(row_reg[i], 2'(j));
    end

    // cross products of each 2x2 minor
    always_comb
    begin
        pa[0] = a[1][1] * a[2][2];  pb[0] = a[1][2] * a[2][1];
        pa[1] = a[1][2] * a[2][0];  pb[1] = a[1][0] * a[2][2];
        pa[2] = a[1][0] * a[2][1];  pb[2] = a[1][1] * a[2][0];
        pa[3] = a[0][2] * a[2][1];  pb[3] = a[0][1] * a[2][2];
        pa[4] = a[0][0] * a[2][2];  pb[4] = a[0][2] * a[2][0];
        pa[5] = a[0][1] * a[2][0];  pb[5] = a[0][0] * a[2][1];
        pa[6] = a[0][1] * a[1][2];  pb[6] = a[0][2] * a[1][1];
        pa[7] = a[0][2] * a[1][0];  pb[7] = a[0][0] * a[1][2];
        pa[8] = a[0][0] * a[1][1];  pb[8] = a[0][1] * a[1][0];
    end

    assign det = DET_W'(rc_dp_reg[0]) + DET_W'(rc_dp_reg[1]) + DET_W'(rc_dp_reg[2]);

    // update sequence: products, cofactors, determinant terms, sign fix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rc_vld_reg <= '0;
        else
            rc_vld_reg <= {rc_vld_reg[2:0], cfg_fire};
    end

    always_ff @(posedge clk)
    begin
        if (rc_vld_reg[0])
        begin
            rc_pa_reg <= pa;
            rc_pb_reg <= pb;
        end
        if (rc_vld_reg[1])
        begin
            for (int k = 0; k < 9; k++)
                rc_cof_reg[k] <= COF_W'(rc_pa_reg[k]) - COF_W'(rc_pb_reg[k]);
        end
        if (rc_vld_reg[2])
        begin
            for (int j = 0; j < 3; j++)
                rc_dp_reg[j] <= a[0][j] * rc_cof_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frozen_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cof_reg[i][j] <= (i == j) ? COF_ONE : COF_ZERO;
        end
        else if (rc_vld_reg[3])
        begin
            frozen_reg <= (det == '0);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cof_reg[i][j] <= det[DET_W-1] ? -rc_cof_reg[3*i+j] : rc_cof_reg[3*i+j];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic adv;
    logic item_fire;
    logic out_vld_reg;

    assign adv        = !(out_vld_reg && result_stall);
    assign item_stall = !adv || rc_busy;
    assign item_fire  = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // stage 1: products
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   n_in [3];
    logic                   s1_vld_reg;
    side_t                  s1_side_reg;
    logic signed [PP_W-1:0] s1_pp_reg [3][3];
    logic signed [ENTRY_W-1:0] s1_tr_reg [3];
    logic signed [NP_W-1:0] s1_np_reg [3][3];

    assign n_in[0] = coord_x;
    assign n_in[1] = coord_y;
    assign n_in[2] = coord_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.kind <= kind;
            s1_side_reg.byp  <= kind && frozen_reg;
            s1_side_reg.neg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                s1_side_reg.val[i] <= n_in[i];
                s1_tr_reg[i]       <= row_entry(row_reg[i], 2'd3);
                for (int j = 0; j < 3; j++)
                begin
                    s1_pp_reg[i][j] <= a[i][j] * n_in[j];
                    s1_np_reg[i][j] <= cof_reg[i][j] * n_in[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sums
    // ------------------------------------------------------------------
    logic                   s2_vld_reg;
    side_t                  s2_side_reg;
    logic signed [PA_W-1:0] s2_acc_reg [3];
    logic signed [TW-1:0]   s2_t_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s1_side_reg;
            for (int i = 0; i < 3; i++)
                s2_acc_reg[i] <= PA_W'(s1_pp_reg[i][0]) + PA_W'(s1_pp_reg[i][1])
                               + PA_W'(s1_pp_reg[i][2])
                               + (PA_W'(s1_tr_reg[i]) <<< FRAC_W) + ROUND_HALF;
            for (int j = 0; j < 3; j++)
                s2_t_reg[j] <= TW'(s1_np_reg[0][j] >>> PRE) + TW'(s1_np_reg[1][j] >>> PRE)
                             + TW'(s1_np_reg[2][j] >>> PRE);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: position rounding and saturation, normal magnitudes
    // ------------------------------------------------------------------
    logic signed [PA_W-1:0] pos_sh [3];
    logic [CW-1:0]          pos_sat [3];
    logic [TW-1:0]          mag [3];
    logic                   s3_vld_reg;
    side_t                  s3_side_reg;
    logic [TW-1:0]          s3_mag_reg [3];
    logic [TW-1:0]          s3_or_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_sh[i] = s2_acc_reg[i] >>> FRAC_W;
            if (pos_sh[i] > POS_MAX)
                pos_sat[i] = POS_MAX[CW-1:0];
            else if (pos_sh[i] < POS_MIN)
                pos_sat[i] = POS_MIN[CW-1:0];
            else
                pos_sat[i] = pos_sh[i][CW-1:0];
            mag[i] = s2_t_reg[i][TW-1] ? TW'(-s2_t_reg[i]) : TW'(s2_t_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.kind <= s2_side_reg.kind;
            for (int i = 0; i < 3; i++)
            begin
                s3_mag_reg[i]         <= mag[i];
                s3_side_reg.neg[i]    <= s2_t_reg[i][TW-1];
                s3_side_reg.val[i]    <= s2_side_reg.kind ? s2_side_reg.val[i] : pos_sat[i];
            end
            s3_side_reg.byp <= !s2_side_reg.kind || s2_side_reg.byp
                             || ((mag[0] | mag[1] | mag[2]) == '0);
            s3_or_reg       <= mag[0] | mag[1] | mag[2];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: leading one of the largest magnitude
    // ------------------------------------------------------------------
    logic [PW-1:0] msb;
    logic          s4_vld_reg;
    side_t         s4_side_reg;
    logic [TW-1:0] s4_mag_reg [3];
    logic [PW-1:0] s4_msb_reg;

    always_comb
    begin
        msb = '0;
        for (int k = 0; k < TW; k++)
            if (s3_or_reg[k])
                msb = PW'(k);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s3_side_reg;
            s4_mag_reg  <= s3_mag_reg;
            s4_msb_reg  <= msb;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: common shift so the largest lies in [2^29, 2^30)
    // ------------------------------------------------------------------
    logic  s5_vld_reg;
    side_t s5_side_reg;
    nm_t   s5_nm_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= s4_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (s4_msb_reg >= PW'(NORM_MSB))
                    s5_nm_reg[i] <= MAG_W'(s4_mag_reg[i] >> (s4_msb_reg - PW'(NORM_MSB)));
                else
                    s5_nm_reg[i] <= MAG_W'(s4_mag_reg[i] << (PW'(NORM_MSB) - s4_msb_reg));
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 6 and 7: squares and their sum
    // ------------------------------------------------------------------
    logic                 s6_vld_reg;
    side_t                s6_side_reg;
    nm_t                  s6_nm_reg;
    logic [2*MAG_W-1:0]   s6_sq_reg [3];
    logic                 s7_vld_reg;
    side_t                s7_side_reg;
    nm_t                  s7_nm_reg;
    logic [SUMSQ_W-1:0]   s7_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_side_reg <= s5_side_reg;
            s6_nm_reg   <= s5_nm_reg;
            for (int i = 0; i < 3; i++)
                s6_sq_reg[i] <= s5_nm_reg[i] * s5_nm_reg[i];
            s7_side_reg <= s6_side_reg;
            s7_nm_reg   <= s6_nm_reg;
            s7_sum_reg  <= SUMSQ_W'(s6_sq_reg[0]) + SUMSQ_W'(s6_sq_reg[1])
                         + SUMSQ_W'(s6_sq_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // square root, dividends, division
    // ------------------------------------------------------------------
    logic              lt_vld_reg  [LATE];
    side_t             lt_side_reg [LATE];
    nm_t               nm_line_reg [ROOT_W];
    logic [ROOT_W-1:0] sq_root;
    logic [DIVD_W-1:0] dvd_reg [3];
    logic [ROOT_W-1:0] dvs_reg;
    logic [QUO_W-1:0]  quo [3];

    vnt_isqrt u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (s7_sum_reg),
        .root     (sq_root)
    );

    // side band and normalised magnitudes follow the square root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lt_side_reg[0] <= s7_side_reg;
            nm_line_reg[0] <= s7_nm_reg;
            for (int k = 1; k < LATE; k++)
                lt_side_reg[k] <= lt_side_reg[k-1];
            for (int k = 1; k < ROOT_W; k++)
                nm_line_reg[k] <= nm_line_reg[k-1];
            for (int i = 0; i < 3; i++)
                dvd_reg[i] <= (DIVD_W'(nm_line_reg[ROOT_W-1][i]) << FRAC_W)
                            + DIVD_W'(sq_root >> 1);
            dvs_reg <= sq_root;
        end
    end

    genvar g;
    for (g = 0; g < 3; g++)
    begin : g_lane
        vnt_div u_div (
            .clk      (clk),
            .en       (adv),
            .dividend (dvd_reg[g]),
            .divisor  (dvs_reg),
            .quotient (quo[g])
        );
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            for (int k = 0; k < LATE; k++)
                lt_vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= item_fire;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            lt_vld_reg[0] <= s7_vld_reg;
            for (int k = 1; k < LATE; k++)
                lt_vld_reg[k] <= lt_vld_reg[k-1];
            out_vld_reg   <= lt_vld_reg[LATE-1];
        end
    end

    // ------------------------------------------------------------------
    // output register: sign of the quotient or the bypass value
    // ------------------------------------------------------------------
    side_t         fin;
    logic [CW-1:0] out_val_next [3];
    logic          out_kind_reg;
    logic [CW-1:0] out_val_reg [3];

    assign fin = lt_side_reg[LATE-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fin.byp)
                out_val_next[i] = fin.val[i];
            else if (fin.neg[i])
                out_val_next[i] = -CW'(quo[i]);
            else
                out_val_next[i] = CW'(quo[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg <= fin.kind;
            out_val_reg  <= out_val_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_kind  = out_kind_reg;
    assign out_x        = out_val_reg[0];
    assign out_y        = out_val_reg[1];
    assign out_z        = out_val_reg[2];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_item_during_update: assert property (@(posedge clk) disable iff (!rst_n)
        rc_busy |-> item_stall)
        else $error("item accepted during cofactor update");

    a_cfg_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !cfg_ready)
        else $error("second configuration transaction during update");

    a_root_normalised: assert property (@(posedge clk) disable iff (!rst_n)
        lt_vld_reg[ROOT_W-1] && !lt_side_reg[ROOT_W-1].byp
            |-> (sq_root[ROOT_W-1:NORM_MSB] != '0))
        else $error("normalised length below range");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lt_vld_reg[LATE-1] && !fin.byp
            |-> (quo[0] <= QUO_W'(4096)) && (quo[1] <= QUO_W'(4096))
                && (quo[2] <= QUO_W'(4096)))
        else $error("normal component above unit length");

endmodule

`default_nettype wire
